// File: rtl/core/tun_pkg.sv
// Package for the triangle unit normal block: widths, pipeline depths
// and the vector type passed between stages. No dependencies.
`timescale 1ns / 1ps
package tun_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 30;
  localparam int OUT_W            = 32;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  // Cross components stay below 2^(2*COORD_BITS+1) in magnitude.
  localparam int MAG_W   = 2 * COORD_BITS + 1;
  localparam int LO_W    = (MAG_W + 1) / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int Q_W     = NORMAL_FRAC_BITS + 1;

  // Sign and magnitude of the three cross product components.
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } vec_t;

endpackage

// File: rtl/core/tun_cross.sv
// Edge vectors and their cross product in three register stages.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_cross (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] a_x_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] a_y_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] a_z_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] b_x_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] b_y_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] b_z_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] c_x_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] c_y_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] c_z_i,
  output logic                                valid_o,
  output tun_pkg::vec_t                       vec_o
);
  import tun_pkg::*;

  logic [2:0] valid_q;
  logic signed [EDGE_W-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [PROD_W-1:0] p_q [6];
  logic signed [CROSS_W-1:0] n_d [3];
  vec_t vec_d, vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q <= EDGE_W'(b_x_i) - EDGE_W'(a_x_i);
    uy_q <= EDGE_W'(b_y_i) - EDGE_W'(a_y_i);
    uz_q <= EDGE_W'(b_z_i) - EDGE_W'(a_z_i);
    vx_q <= EDGE_W'(c_x_i) - EDGE_W'(a_x_i);
    vy_q <= EDGE_W'(c_y_i) - EDGE_W'(a_y_i);
    vz_q <= EDGE_W'(c_z_i) - EDGE_W'(a_z_i);
    p_q[0] <= PROD_W'(uy_q) * PROD_W'(vz_q);
    p_q[1] <= PROD_W'(uz_q) * PROD_W'(vy_q);
    p_q[2] <= PROD_W'(uz_q) * PROD_W'(vx_q);
    p_q[3] <= PROD_W'(ux_q) * PROD_W'(vz_q);
    p_q[4] <= PROD_W'(ux_q) * PROD_W'(vy_q);
    p_q[5] <= PROD_W'(uy_q) * PROD_W'(vx_q);
    vec_q <= vec_d;
  end

  always_comb begin
    logic signed [CROSS_W-1:0] abs_v;
    vec_d = '0;
    for (int c = 0; c < 3; c++) begin
      n_d[c] = CROSS_W'(p_q[2*c]) - CROSS_W'(p_q[2*c+1]);
      abs_v = n_d[c][CROSS_W-1] ? -n_d[c] : n_d[c];
      vec_d.neg[c] = n_d[c][CROSS_W-1];
      vec_d.mag[c] = abs_v[MAG_W-1:0];
    end
  end

  assign valid_o = valid_q[2];
  assign vec_o   = vec_q;

endmodule

// File: rtl/core/tun_sqlen.sv
// Squared length of the cross product: split squares, then sums.
// Three register stages. Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_sqlen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  tun_pkg::vec_t              vec_i,
  output logic                       valid_o,
  output logic [tun_pkg::SUM_W-1:0]  sum_o,
  output tun_pkg::vec_t              vec_o
);
  import tun_pkg::*;

  logic [2:0] valid_q;
  vec_t vec_q [3];
  logic [2*LO_W-1:0]      ll_q [3];
  logic [LO_W+HI_W-1:0]   lh_q [3];
  logic [2*HI_W-1:0]      hh_q [3];
  logic [SQ_W-1:0]        sq_q [3];
  logic [SUM_W-1:0]       sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q[0] <= vec_i;
    vec_q[1] <= vec_q[0];
    vec_q[2] <= vec_q[1];
    for (int c = 0; c < 3; c++) begin
      ll_q[c] <= (2*LO_W)'(vec_i.mag[c][LO_W-1:0]) * (2*LO_W)'(vec_i.mag[c][LO_W-1:0]);
      lh_q[c] <= (LO_W+HI_W)'(vec_i.mag[c][LO_W-1:0])
                 * (LO_W+HI_W)'(vec_i.mag[c][MAG_W-1:LO_W]);
      hh_q[c] <= (2*HI_W)'(vec_i.mag[c][MAG_W-1:LO_W])
                 * (2*HI_W)'(vec_i.mag[c][MAG_W-1:LO_W]);
      sq_q[c] <= (SQ_W'(hh_q[c]) << (2*LO_W)) + (SQ_W'(lh_q[c]) << (LO_W+1))
                 + SQ_W'(ll_q[c]);
    end
    sum_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  end

  assign valid_o = valid_q[2];
  assign sum_o   = sum_q;
  assign vec_o   = vec_q[2];

endmodule

// File: rtl/core/tun_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [tun_pkg::SUM_W-1:0]   sum_i,
  input  tun_pkg::vec_t               vec_i,
  output logic                        valid_o,
  output logic [tun_pkg::ROOT_W-1:0]  root_o,
  output tun_pkg::vec_t               vec_o
);
  import tun_pkg::*;

  logic [ROOT_W:0]   valid_q;
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [SUM_W-1:0]  rad_q  [ROOT_W+1];
  vec_t              vec_q  [ROOT_W+1];

  assign valid_q[0] = valid_i;
  assign rem_q[0]   = '0;
  assign root_q[0]  = '0;
  assign rad_q[0]   = sum_i;
  assign vec_q[0]   = vec_i;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0]  rem_t, trial, rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      rem_t = {rem_q[s][REM_W-3:0], rad_q[s][SUM_W-1 -: 2]};
      trial = REM_W'({root_q[s], 2'b01});
      if (rem_t >= trial) begin
        rem_d  = rem_t - trial;
        root_d = {root_q[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_t;
        root_d = {root_q[s][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_d;
      root_q[s+1] <= root_d;
      rad_q[s+1]  <= rad_q[s] << 2;
      vec_q[s+1]  <= vec_q[s];
    end
  end

  assign valid_o = valid_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign vec_o   = vec_q[ROOT_W];

endmodule

// File: rtl/core/tun_div.sv
// Pipelined restoring divider: one normal component over the length,
// one quotient bit per stage, sign applied at the end. Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               neg_i,
  input  logic [tun_pkg::MAG_W-1:0]          mag_i,
  input  logic [tun_pkg::ROOT_W-1:0]         den_i,
  output logic                               valid_o,
  output logic                               degen_o,
  output logic signed [tun_pkg::OUT_W-1:0]   norm_o
);
  import tun_pkg::*;

  logic [Q_W:0]      valid_q;
  logic [ROOT_W-1:0] rem_q [Q_W+1];
  logic [ROOT_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0]    quo_q [Q_W+1];
  logic [Q_W:0]      neg_q;
  logic [Q_W:0]      zero_q;
  logic [OUT_W-1:0]  quo_ext;

  assign valid_q[0] = valid_i;
  // The numerator is mag * 2^frac: its top part seeds the remainder and
  // only its lowest bit (mag bit 0) enters at the first step.
  assign rem_q[0]   = ROOT_W'(mag_i >> 1);
  assign den_q[0]   = den_i;
  assign quo_q[0]   = '0;
  assign neg_q[0]   = neg_i;
  assign zero_q[0]  = (den_i == '0);

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [ROOT_W:0]   rem_t;
    logic [ROOT_W-1:0] rem_d;
    logic              bit_d;

    always_comb begin
      rem_t = {rem_q[s], (s == 0) ? mag_i[0] : 1'b0};
      if (rem_t >= {1'b0, den_q[s]}) begin
        rem_d = ROOT_W'(rem_t - {1'b0, den_q[s]});
        bit_d = 1'b1;
      end else begin
        rem_d = rem_t[ROOT_W-1:0];
        bit_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_d;
      den_q[s+1]  <= den_q[s];
      quo_q[s+1]  <= {quo_q[s][Q_W-2:0], bit_d};
      neg_q[s+1]  <= neg_q[s];
      zero_q[s+1] <= zero_q[s];
    end
  end

  assign quo_ext = OUT_W'(quo_q[Q_W]);
  assign valid_o = valid_q[Q_W];
  assign degen_o = zero_q[Q_W];
  assign norm_o  = zero_q[Q_W] ? '0 : (neg_q[Q_W] ? -quo_ext : quo_ext);

endmodule

// File: rtl/core/triangle_unit_normal_unit.sv
// Top level of the triangle unit normal block: cross product, squared
// length, square root and three dividers. Depends on tun_pkg and tun_*.
//
//  port group        dir  handshake         contents
//  corner_*_i        in   start_i, busy     three corners, signed Q12.12
//  normal_*_o, deg.  out  done_o            unit normal Q2.30, degenerate flag
//
// A face enters on any cycle with start_i high; busy stays low.
// From the accepting edge to the edge that takes its result, each face
// passes six arithmetic stages, one per root bit (50), one per quotient
// bit (31) and one output register. A new face may enter every cycle.
// A result is shown for one cycle with done_o and cannot be held off.
// Reset clears only the valid bits; faces in flight are dropped.
`timescale 1ns / 1ps
module triangle_unit_normal_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_a_x_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_a_y_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_a_z_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_b_x_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_b_y_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_b_z_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_c_x_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_c_y_i,
  input  logic signed [tun_pkg::COORD_BITS-1:0] corner_c_z_i,
  output logic                                  done_o,
  output logic signed [tun_pkg::OUT_W-1:0]      normal_x_o,
  output logic signed [tun_pkg::OUT_W-1:0]      normal_y_o,
  output logic signed [tun_pkg::OUT_W-1:0]      normal_z_o,
  output logic                                  degenerate_o
);
  import tun_pkg::*;

  localparam int LATENCY = 6 + ROOT_W + Q_W + 1;

  logic              cr_valid, sl_valid, sq_valid;
  vec_t              cr_vec, sl_vec, sq_vec;
  logic [SUM_W-1:0]  sl_sum;
  logic [ROOT_W-1:0] sq_root;
  logic [2:0]        dv_valid, dv_degen;
  logic signed [OUT_W-1:0] dv_norm [3];

  logic                    done_q, degen_q;
  logic signed [OUT_W-1:0] nx_q, ny_q, nz_q;

  assign busy = 1'b0;

  tun_cross u_cross (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .a_x_i (corner_a_x_i), .a_y_i (corner_a_y_i), .a_z_i (corner_a_z_i),
    .b_x_i (corner_b_x_i), .b_y_i (corner_b_y_i), .b_z_i (corner_b_z_i),
    .c_x_i (corner_c_x_i), .c_y_i (corner_c_y_i), .c_z_i (corner_c_z_i),
    .valid_o (cr_valid),
    .vec_o   (cr_vec)
  );

  tun_sqlen u_sqlen (
    .clk_i, .rst_ni,
    .valid_i (cr_valid),
    .vec_i   (cr_vec),
    .valid_o (sl_valid),
    .sum_o   (sl_sum),
    .vec_o   (sl_vec)
  );

  tun_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (sl_valid),
    .sum_i   (sl_sum),
    .vec_i   (sl_vec),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .vec_o   (sq_vec)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div
    tun_div u_div (
      .clk_i, .rst_ni,
      .valid_i (sq_valid),
      .neg_i   (sq_vec.neg[c]),
      .mag_i   (sq_vec.mag[c]),
      .den_i   (sq_root),
      .valid_o (dv_valid[c]),
      .degen_o (dv_degen[c]),
      .norm_o  (dv_norm[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid[0];
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q    <= dv_norm[0];
    ny_q    <= dv_norm[1];
    nz_q    <= dv_norm[2];
    degen_q <= dv_degen[0];
  end

  assign done_o       = done_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign degenerate_o = degen_q;

  // All three dividers run in lockstep on the same length.
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[0] |-> (dv_valid[1] && dv_valid[2] && dv_degen[1] == dv_degen[0]
                     && dv_degen[2] == dv_degen[0]))
    else $error("divider lanes out of step");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (normal_x_o == '0 && normal_y_o == '0
                                  && normal_z_o == '0))
    else $error("degenerate face with nonzero normal");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o)
    else $error("accepted face produced no result");

endmodule
